// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the divergence finder RTL.
// The macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dpdf_pkg.sv =====
// Package for the delta/price divergence finder: field widths, sequencer states and the
// structures passed between the sequencer and the comparator unit. Depends on nothing.
`timescale 1ns / 1ps

package dpdf_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int INDEX_W      = 32;
	localparam int PAIR_W       = 2 * SAMPLE_W;
	localparam int LOOKBACK_W   = 5;
	localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 5'd5;
	localparam logic [INDEX_W-1:0]    INDEX_MAX      = {INDEX_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_SCAN,
		ST_LAST,
		ST_EMIT
	} state_t;

	// Tags the word arriving from the window memory.
	typedef struct packed {
		logic load_centre;
		logic compare;
	} cmp_ctl_t;

	typedef struct packed {
		logic d_peak;
		logic d_trough;
		logic p_peak;
		logic p_trough;
	} cmp_flags_t;

endpackage

// ===== hdl/dpdf_chan_if.sv =====
// Valid/ready channel interfaces of the divergence finder: sample input, result output and
// the lookback configuration write channel. Depends on dpdf_pkg.
`timescale 1ns / 1ps

interface dpdf_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 series_start;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] delta_sample;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] price_sample;

	modport source (output valid, series_start, delta_sample, price_sample, input ready);
	modport sink (input valid, series_start, delta_sample, price_sample, output ready);
endinterface

interface dpdf_result_if;
	logic                                 valid;
	logic                                 ready;
	logic        [dpdf_pkg::INDEX_W-1:0]  centre_index;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] centre_delta;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] centre_price;
	logic                                 bullish;

	modport source (output valid, centre_index, centre_delta, centre_price, bullish,
		input ready);
	modport sink (input valid, centre_index, centre_delta, centre_price, bullish,
		output ready);
endinterface

interface dpdf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dpdf_pkg::LOOKBACK_W-1:0]     lookback;

	modport source (output valid, lookback, input ready);
	modport sink (input valid, lookback, output ready);
endinterface

// ===== hdl/delta_price_divergence_finder.sv =====
// Delta/price divergence finder top level: window memory, sequencer and result register.
// Depends on dpdf_pkg, dpdf_chan_if, dpdf_ram, dpdf_cmp and assert_macros.svh.
`timescale 1ns / 1ps

// Each word on the samples channel carries one bar (delta and price in signed Q16.16) and
// is written into a circular window memory of the last 2*MAX_LOOKBACK+1 bars, so no
// sample is ever moved once stored. A word that leaves the series shorter than
// 2*lookback+1 bars is finished in its acceptance cycle and yields no result. Otherwise
// the sequencer reads the centre bar, lookback places behind the newest, and then the
// 2*lookback neighbours one per cycle through the single read port of the memory; that
// read port sets the rate. A found divergence goes into an output register, which lets
// the next sample word be taken while the result still waits; if a second result is
// ready before the first has gone, the sequencer holds it until the output register is
// free. The memory needs no clearing after reset: the series length count guarantees
// that only bars of the current series are ever read. The lookback register may be
// written only while the block is idle; a value of zero acts as one and a value above
// MAX_LOOKBACK acts as MAX_LOOKBACK.
module delta_price_divergence_finder #(
	parameter int MAX_LOOKBACK = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	dpdf_sample_if.sink   samples,
	dpdf_result_if.source results,
	dpdf_cfg_if.sink      cfg
);

`include "assert_macros.svh"

	localparam int WIN_DEPTH = 2 * MAX_LOOKBACK + 1;
	localparam int AW        = $clog2(WIN_DEPTH);
	localparam int RAM_DEPTH = 1 << AW;
	localparam int LB_W      = $clog2(MAX_LOOKBACK + 1);

	dpdf_pkg::state_t state_q, state_d;

	logic [AW-1:0]                     wp_q;
	logic [AW-1:0]                     wp_next;
	logic [AW-1:0]                     off_q;
	logic [AW-1:0]                     off_inc;
	logic [AW-1:0]                     two_lb;
	logic [AW-1:0]                     raddr;
	logic [dpdf_pkg::INDEX_W-1:0]      count_q;
	logic [dpdf_pkg::INDEX_W-1:0]      new_count;
	logic [dpdf_pkg::INDEX_W-1:0]      idx_q;
	logic [dpdf_pkg::LOOKBACK_W-1:0]   lookback_q;
	logic [LB_W-1:0]                   lb_c;
	logic [LB_W-1:0]                   lb_q;
	logic                              in_acc;
	logic                              win_full;
	logic                              hit;
	logic                              out_free;
	logic                              load_out;
	logic [dpdf_pkg::PAIR_W-1:0]       rdata;
	dpdf_pkg::cmp_ctl_t                ctl_d, ctl_s1;
	dpdf_pkg::cmp_flags_t              flags;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] cd, cp;

	logic                                 out_valid_q;
	logic [dpdf_pkg::INDEX_W-1:0]         out_index_q;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] out_delta_q;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] out_price_q;
	logic                                 out_bull_q;

	// Handshakes.
	assign in_acc        = samples.valid && samples.ready;
	assign samples.ready = (state_q == dpdf_pkg::ST_IDLE);
	assign cfg.ready     = 1'b1;

	// Effective lookback: zero acts as one, anything above the maximum is clipped.
	always_comb begin
		if (lookback_q == '0) begin
			lb_c = LB_W'(1);
		end else if (32'(lookback_q) > MAX_LOOKBACK) begin
			lb_c = LB_W'(MAX_LOOKBACK);
		end else begin
			lb_c = LB_W'(lookback_q);
		end
	end

	// The series count restarts on a series start and saturates at its maximum.
	always_comb begin
		if (samples.series_start) begin
			new_count = dpdf_pkg::INDEX_W'(1);
		end else if (count_q == dpdf_pkg::INDEX_MAX) begin
			new_count = dpdf_pkg::INDEX_MAX;
		end else begin
			new_count = count_q + dpdf_pkg::INDEX_W'(1);
		end
	end

	// The window is full once the series holds 2*lookback+1 bars.
	assign win_full = (new_count >= dpdf_pkg::INDEX_W'({lb_c, 1'b1}));
	assign wp_next  = wp_q + AW'(1);
	assign two_lb   = AW'({lb_q, 1'b0});
	assign off_inc  = off_q + AW'(1);

	assign hit      = (flags.d_peak && flags.p_trough) || (flags.d_trough && flags.p_peak);
	assign out_free = !out_valid_q || results.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpdf_pkg::ST_IDLE: begin
				if (in_acc && win_full) begin
					state_d = dpdf_pkg::ST_CENTRE;
				end
			end
			dpdf_pkg::ST_CENTRE: begin
				state_d = dpdf_pkg::ST_SCAN;
			end
			dpdf_pkg::ST_SCAN: begin
				if (off_q == two_lb) begin
					state_d = dpdf_pkg::ST_LAST;
				end
			end
			dpdf_pkg::ST_LAST: begin
				state_d = dpdf_pkg::ST_EMIT;
			end
			dpdf_pkg::ST_EMIT: begin
				if (!hit || out_free) begin
					state_d = dpdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpdf_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. Offsets count back from the newest bar; the centre is read first.
	always_comb begin
		ctl_d    = '0;
		raddr    = wp_q;
		load_out = 1'b0;
		unique case (state_q)
			dpdf_pkg::ST_CENTRE: begin
				raddr             = wp_q - AW'(lb_q);
				ctl_d.load_centre = 1'b1;
			end
			dpdf_pkg::ST_SCAN: begin
				raddr         = wp_q - off_q;
				ctl_d.compare = 1'b1;
			end
			dpdf_pkg::ST_EMIT: begin
				load_out = hit && out_free;
			end
			default: begin
				ctl_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpdf_pkg::ST_IDLE;
			wp_q        <= '0;
			count_q     <= '0;
			lookback_q  <= dpdf_pkg::LOOKBACK_RESET;
			lb_q        <= LB_W'(1);
			off_q       <= '0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= ctl_d;
			if (cfg.valid && cfg.ready) begin
				lookback_q <= cfg.lookback;
			end
			if (in_acc) begin
				wp_q    <= wp_next;
				count_q <= new_count;
				lb_q    <= lb_c;
			end
			// Walk the neighbours and step over the centre itself.
			if (state_q == dpdf_pkg::ST_CENTRE) begin
				off_q <= '0;
			end else if (state_q == dpdf_pkg::ST_SCAN) begin
				off_q <= (off_inc == AW'(lb_q)) ? off_q + AW'(2) : off_inc;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Centre index is fixed when the word is accepted; it saturates with the count.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (new_count == dpdf_pkg::INDEX_MAX) begin
				idx_q <= dpdf_pkg::INDEX_MAX;
			end else begin
				idx_q <= new_count - dpdf_pkg::INDEX_W'(lb_c) - dpdf_pkg::INDEX_W'(1);
			end
		end
		if (load_out) begin
			out_index_q <= idx_q;
			out_delta_q <= cd;
			out_price_q <= cp;
			out_bull_q  <= flags.d_peak && flags.p_trough;
		end
	end

	dpdf_ram #(
		.WIDTH (dpdf_pkg::PAIR_W),
		.DEPTH (RAM_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (in_acc),
		.waddr (wp_next),
		.wdata ({samples.delta_sample, samples.price_sample}),
		.raddr (raddr),
		.rdata (rdata)
	);

	dpdf_cmp u_cmp (
		.clk          (clk),
		.ctl          (ctl_s1),
		.rd_delta     (rdata[dpdf_pkg::PAIR_W-1:dpdf_pkg::SAMPLE_W]),
		.rd_price     (rdata[dpdf_pkg::SAMPLE_W-1:0]),
		.centre_delta (cd),
		.centre_price (cp),
		.flags        (flags)
	);

	assign results.valid        = out_valid_q;
	assign results.centre_index = out_index_q;
	assign results.centre_delta = out_delta_q;
	assign results.centre_price = out_price_q;
	assign results.bullish      = out_bull_q;

	`ASSERT_IMPLIES(a_off_not_centre, state_q == dpdf_pkg::ST_SCAN, off_q != AW'(lb_q), "scan offset landed on the centre bar")
	`ASSERT_IMPLIES(a_off_bound, state_q == dpdf_pkg::ST_SCAN, off_q <= two_lb, "scan offset ran past the window")
	`ASSERT_NEXT(a_short_series, in_acc && !win_full, state_q == dpdf_pkg::ST_IDLE, "short series left the sequencer busy")
	`ASSERT_IMPLIES(a_one_pattern, state_q == dpdf_pkg::ST_EMIT, !((flags.d_peak && flags.p_trough) && (flags.d_trough && flags.p_peak)), "bullish and bearish flagged together")

endmodule

// ===== hdl/dpdf_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dpdf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/dpdf_cmp.sv =====
// Comparator unit: holds the centre pair and folds one neighbour pair per cycle into the
// peak and trough flags. Depends on dpdf_pkg.
`timescale 1ns / 1ps

module dpdf_cmp (
	input  logic                                 clk,
	input  dpdf_pkg::cmp_ctl_t                   ctl,
	input  logic signed [dpdf_pkg::SAMPLE_W-1:0] rd_delta,
	input  logic signed [dpdf_pkg::SAMPLE_W-1:0] rd_price,
	output logic signed [dpdf_pkg::SAMPLE_W-1:0] centre_delta,
	output logic signed [dpdf_pkg::SAMPLE_W-1:0] centre_price,
	output dpdf_pkg::cmp_flags_t                 flags
);

	logic signed [dpdf_pkg::SAMPLE_W-1:0] cd_q;
	logic signed [dpdf_pkg::SAMPLE_W-1:0] cp_q;
	dpdf_pkg::cmp_flags_t                 flags_q;

	always_ff @(posedge clk) begin
		if (ctl.load_centre) begin
			cd_q    <= rd_delta;
			cp_q    <= rd_price;
			flags_q <= '1;
		end else if (ctl.compare) begin
			// A neighbour that ties the centre breaks both the peak and the trough.
			flags_q.d_peak   <= flags_q.d_peak   && (rd_delta < cd_q);
			flags_q.d_trough <= flags_q.d_trough && (cd_q < rd_delta);
			flags_q.p_peak   <= flags_q.p_peak   && (rd_price < cp_q);
			flags_q.p_trough <= flags_q.p_trough && (cp_q < rd_price);
		end
	end

	assign centre_delta = cd_q;
	assign centre_price = cp_q;
	assign flags        = flags_q;

endmodule
